>>> hw/rtl/swr_pkg.sv
// shared widths, register map and parameter defaults for the sliding window receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

    // fixed field widths of the frame header and ack beats
    localparam int NODE_W = 4;
    localparam int SEQ_W  = 8;

    // width used to range-check a sender id against the sender count
    localparam int SRC_CMP_W = 9;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_OWN_NODE_ID = 1'b0;

    // parameter defaults
    localparam int DEF_NUM_SENDERS = 16;
    localparam int DEF_WINDOW_SIZE = 8;
    localparam int DEF_SEQ_SPACE   = 256;

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_receiver.sv
// sliding window receiver: per-sender window state kept in two synchronous memories
// depends on swr_pkg
// after its header beat is accepted, an ack beat reaches o_valid through r_busy and then r_valid
// a delivered header (row read, then modify and write back) raises busy, so no new header is taken until it is done;
//   a dropped header (corrupt, foreign or unknown sender) does not raise busy and gives no beat
// the receiver of ack beats cannot stall: each ack is on the ports for exactly one cycle
// reset (sync, active low) clears own_node_id and the per-sender row valid bits,
//   so every sender reads as next expected = 1 with an empty window; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_receiver
    import swr_pkg::*;
#(
    parameter int NUM_SENDERS = DEF_NUM_SENDERS,
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
    parameter int SEQ_SPACE   = DEF_SEQ_SPACE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // header beats
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [NODE_W-1:0]     i_source_node,
    input  wire logic [NODE_W-1:0]     i_dest_node,
    input  wire logic [SEQ_W-1:0]      i_seq_num,
    input  wire logic                  i_is_corrupt,

    // ack beats
    output logic                       o_valid,
    output logic [NODE_W-1:0]          o_ack_to_node,
    output logic [SEQ_W-1:0]           o_ack_seq,
    output logic                       o_ack_is_resend,

    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // widths derived from the parameters
    localparam int NE_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int SW    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int SRC_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
    localparam int CW    = (NE_W > SEQ_W) ? NE_W : SEQ_W;
    localparam int DW    = CW + 1;
    localparam int CTL_W = NE_W + SW + WINDOW_SIZE;
    localparam int SEQS_W = WINDOW_SIZE * SEQ_W;
    localparam int TAB_N = 2 ** SEQ_W;

    // reset view of a sender row
    localparam logic [NE_W-1:0] NE_RST = NE_W'(1 % SEQ_SPACE);
    localparam logic [SW-1:0]   NS_RST = SW'((1 % SEQ_SPACE) % WINDOW_SIZE);

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    logic [NODE_W-1:0] r_own;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
        end else if (w_cfg_wr && (paddr[2] == REG_OWN_NODE_ID)) begin
            r_own <= pwdata[NODE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_OWN_NODE_ID) begin
            prdata = APB_DATA_W'(r_own);
        end
    end

    // ---------------------------------------------------------------
    // header accept and filtering
    // ---------------------------------------------------------------
    logic             r_busy;
    logic             w_accept;
    logic             w_src_ok;
    logic             w_act;
    logic [SRC_W-1:0] w_src_idx;

    // slot of a sequence number: constant table over the whole 8-bit range
    logic [SW-1:0] w_mod_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_mod_tab
        assign w_mod_tab[g] = SW'(g % WINDOW_SIZE);
    end

    assign busy      = r_busy;
    assign w_accept  = start & ~r_busy;
    assign w_src_ok  = SRC_CMP_W'(i_source_node) < SRC_CMP_W'(NUM_SENDERS);
    assign w_src_idx = SRC_W'(i_source_node);
    // frames that are corrupt, foreign or from an unknown sender are dropped right away
    assign w_act     = ~i_is_corrupt & (i_dest_node == r_own) & w_src_ok;

    // beat captured for the compute cycle
    logic [SRC_W-1:0]  r_src_idx;
    logic [NODE_W-1:0] r_src_node;
    logic [SEQ_W-1:0]  r_seq;
    logic [SW-1:0]     r_slot;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src_idx  <= w_src_idx;
            r_src_node <= i_source_node;
            r_seq      <= i_seq_num;
            r_slot     <= w_mod_tab[i_seq_num];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_accept & w_act;
        end
    end

    // ---------------------------------------------------------------
    // sender state memories
    // control row: next expected, its slot, received marks
    // seq row: stored sequence number per slot
    // ---------------------------------------------------------------
    logic [CTL_W-1:0]       r_ctl_mem [NUM_SENDERS];
    logic [SEQS_W-1:0]      r_seq_mem [NUM_SENDERS];
    logic [NUM_SENDERS-1:0] r_row_vld;
    logic [CTL_W-1:0]       r_rd_ctl;
    logic [SEQS_W-1:0]      r_rd_seq;
    logic                   r_rd_vld;
    logic                   w_wr_en;
    logic [CTL_W-1:0]       w_wr_ctl;
    logic [SEQS_W-1:0]      w_wr_seq;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_act) begin
            r_rd_ctl <= r_ctl_mem[w_src_idx];
            r_rd_seq <= r_seq_mem[w_src_idx];
        end
        if (w_wr_en) begin
            r_ctl_mem[r_src_idx] <= w_wr_ctl;
            r_seq_mem[r_src_idx] <= w_wr_seq;
        end
    end

    // row valid bits give the reset view without sweeping the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (w_accept && w_act) begin
                r_rd_vld <= r_row_vld[w_src_idx];
            end
            if (w_wr_en) begin
                r_row_vld[r_src_idx] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // compute cycle: window test, mark, advance, write back
    // the write lands before the next header can be read, so no forwarding
    // ---------------------------------------------------------------
    logic [NE_W-1:0]        w_ne;
    logic [SW-1:0]          w_ns;
    logic [WINDOW_SIZE-1:0] w_rcv;
    logic [SEQ_W-1:0]       w_seqs [WINDOW_SIZE];

    assign w_ne  = r_rd_vld ? r_rd_ctl[CTL_W-1 -: NE_W]           : NE_RST;
    assign w_ns  = r_rd_vld ? r_rd_ctl[WINDOW_SIZE +: SW]         : NS_RST;
    assign w_rcv = r_rd_vld ? r_rd_ctl[WINDOW_SIZE-1:0]           : '0;

    for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_seq_unpack
        assign w_seqs[j] = r_rd_seq[j*SEQ_W +: SEQ_W];
    end

    // window test: (seq - next expected) mod space below the window size
    logic [DW-1:0] w_seq_x;
    logic [DW-1:0] w_ne_x;
    logic [DW-1:0] w_diff;
    logic          w_in_win;
    logic          w_dup;
    logic          w_resend;

    assign w_seq_x  = DW'(r_seq);
    assign w_ne_x   = DW'(w_ne);
    assign w_diff   = (w_seq_x >= w_ne_x) ? (w_seq_x - w_ne_x)
                                          : (w_seq_x + DW'(SEQ_SPACE) - w_ne_x);
    assign w_in_win = (w_seq_x < DW'(SEQ_SPACE)) && (w_diff < DW'(WINDOW_SIZE));
    assign w_dup    = w_rcv[r_slot] && (w_seqs[r_slot] == r_seq);
    assign w_resend = w_dup | ~w_in_win;

    // window after marking the new frame (a stale slot is overwritten)
    logic [WINDOW_SIZE-1:0] w_rcv_m;
    logic [SEQ_W-1:0]       w_seqs_m [WINDOW_SIZE];

    always_comb begin
        w_rcv_m = w_rcv;
        w_rcv_m[r_slot] = 1'b1;
    end

    for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_mark
        assign w_seqs_m[j] = (r_slot == SW'(j)) ? r_seq : w_seqs[j];
    end

    // candidate expected number and slot for each advance step, plus one past the window
    logic [NE_W-1:0] w_e [WINDOW_SIZE+1];
    logic [SW-1:0]   w_k [WINDOW_SIZE+1];

    for (genvar j = 0; j <= WINDOW_SIZE; j++) begin : g_step
        logic [DW-1:0] w_esum;
        logic          w_wrap;
        logic [SW:0]   w_ksum;
        logic [SW:0]   w_kred;

        assign w_esum = w_ne_x + DW'(j % SEQ_SPACE);
        assign w_wrap = w_esum >= DW'(SEQ_SPACE);
        assign w_e[j] = w_wrap ? NE_W'(w_esum - DW'(SEQ_SPACE)) : NE_W'(w_esum);
        // no wrap: slot steps on from the stored slot; after a wrap the number is below
        // the window size and is its own slot
        assign w_ksum = (SW+1)'(w_ns) + (SW+1)'(j % WINDOW_SIZE);
        assign w_kred = (w_ksum >= (SW+1)'(WINDOW_SIZE)) ? (w_ksum - (SW+1)'(WINDOW_SIZE))
                                                         : w_ksum;
        assign w_k[j] = w_wrap ? SW'(w_e[j]) : w_kred[SW-1:0];
    end

    // advance run: leading in-order received slots; a slot seen twice in one run was
    // already cleared, so the run stops there
    logic [WINDOW_SIZE-1:0] w_hit;
    logic [WINDOW_SIZE-1:0] w_run;
    logic [WINDOW_SIZE-1:0] w_rcv_n;
    logic [NE_W-1:0]        w_ne_new;
    logic [SW-1:0]          w_ns_new;
    logic                   w_rep;

    always_comb begin
        w_hit = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            w_rep = 1'b0;
            for (int i = 0; i < j; i++) begin
                if (w_k[i] == w_k[j]) begin
                    w_rep = 1'b1;
                end
            end
            w_hit[j] = w_rcv_m[w_k[j]] && (CW'(w_seqs_m[w_k[j]]) == CW'(w_e[j])) && !w_rep;
        end

        w_run[0] = w_hit[0];
        for (int j = 1; j < WINDOW_SIZE; j++) begin
            w_run[j] = w_run[j-1] & w_hit[j];
        end

        // first step that fails sets the new expected number
        w_ne_new = w_e[WINDOW_SIZE];
        w_ns_new = w_k[WINDOW_SIZE];
        for (int j = WINDOW_SIZE - 1; j >= 0; j--) begin
            if (!w_run[j]) begin
                w_ne_new = w_e[j];
                w_ns_new = w_k[j];
            end
        end

        // passed slots are cleared
        w_rcv_n = w_rcv_m;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (w_run[j]) begin
                w_rcv_n[w_k[j]] = 1'b0;
            end
        end
    end

    assign w_wr_en  = r_busy & ~w_resend;
    assign w_wr_ctl = {w_ne_new, w_ns_new, w_rcv_n};

    always_comb begin
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            w_wr_seq[j*SEQ_W +: SEQ_W] = w_seqs_m[j];
        end
    end

    // ack number is the expected number minus one, wrapped into the sequence space
    logic [NE_W-1:0] w_ack_base;
    logic [NE_W-1:0] w_ack;

    assign w_ack_base = w_resend ? w_ne : w_ne_new;
    assign w_ack      = (w_ack_base == '0) ? NE_W'(SEQ_SPACE - 1) : (w_ack_base - NE_W'(1));

    // ---------------------------------------------------------------
    // ack output register
    // ---------------------------------------------------------------
    logic r_valid;
    logic [NODE_W-1:0] r_ack_node;
    logic [SEQ_W-1:0]  r_ack_seq;
    logic              r_ack_resend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_ack_node   <= r_src_node;
            r_ack_seq    <= SEQ_W'(w_ack);
            r_ack_resend <= w_resend;
        end
    end

    assign o_valid         = r_valid;
    assign o_ack_to_node   = r_ack_node;
    assign o_ack_seq       = r_ack_seq;
    assign o_ack_is_resend = r_ack_resend;

endmodule

`default_nettype wire
